FILE: src/tpsd_pkg.sv
// ----------------------------------------------------------------------------
// tpsd_pkg
// Shared types and constants for the TGA pixel stream decoder.
// ----------------------------------------------------------------------------
package tpsd_pkg;

    // Configuration register indexes
    localparam logic [7:0] REG_RUN_LENGTH   = 8'd0;
    localparam logic [7:0] REG_PIXEL_FORMAT = 8'd1;
    localparam logic [7:0] REG_IMAGE_WIDTH  = 8'd2;
    localparam logic [7:0] REG_IMAGE_HEIGHT = 8'd3;

    // Pixel format codes
    typedef enum logic [1:0] {
        FMT_GRAY8  = 2'd0,
        FMT_ARGB16 = 2'd1,
        FMT_BGR24  = 2'd2,
        FMT_BGRA32 = 2'd3
    } pixel_fmt_t;

    localparam logic [7:0] RUN_FLAG     = 8'h80;
    localparam logic [6:0] COUNT_MASK   = 7'h7F;
    localparam logic [7:0] OPAQUE_ALPHA = 8'd255;

    // Live configuration as seen by the decoder
    typedef struct packed {
        logic       run_length_coded;
        pixel_fmt_t pixel_format;
    } cfg_t;

    // One decoded result
    typedef struct packed {
        logic        image_end;
        logic [7:0]  repeat_count;
        logic [31:0] pixel_value;
    } res_t;

    // Decoder status towards the top level
    typedef struct packed {
        logic image_done;
    } dec_status_t;

endpackage

FILE: src/tpsd_decode.sv
// ----------------------------------------------------------------------------
// tpsd_decode
// Packet and pixel state for the decoder. One byte is consumed per fire; a
// completed pixel is widened to BGRA and handed out with its repeat count.
// ----------------------------------------------------------------------------
module tpsd_decode (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  logic [7:0]           data_byte,
    input  tpsd_pkg::cfg_t       cfg,
    input  logic                 restart,
    input  logic [31:0]          restart_pixels,
    output logic                 res_valid,
    output tpsd_pkg::res_t       res,
    output tpsd_pkg::dec_status_t status
);
    import tpsd_pkg::*;

    logic [31:0] pixels_left_reg, pixels_left_next;
    logic [7:0]  packet_left_reg, packet_left_next;
    logic        packet_is_run_reg, packet_is_run_next;
    logic [1:0]  byte_phase_reg, byte_phase_next;
    logic [23:0] partial_reg, partial_next;

    logic [31:0] word;
    logic [7:0]  repeat_raw;
    logic [7:0]  repeat_sat;

    // Widen a gathered pixel word to BGRA
    function automatic logic [31:0] widen(input pixel_fmt_t fmt, input logic [31:0] w);
        logic [31:0] p;
        p = 32'd0;
        case (fmt)
            FMT_GRAY8: begin
                p = {24'd0, w[7:0]};
            end
            FMT_ARGB16: begin
                p = {w[15], 7'd0, w[14:10], 3'd0, w[9:5], 3'd0, w[4:0], 3'd0};
            end
            FMT_BGR24: begin
                p = {OPAQUE_ALPHA, w[23:0]};
            end
            default: begin
                p = w;
            end
        endcase
        return p;
    endfunction

    // Assemble the final byte onto the gathered bytes
    always_comb begin
        case (cfg.pixel_format)
            FMT_GRAY8:  word = {24'd0, data_byte};
            FMT_ARGB16: word = {16'd0, data_byte, partial_reg[7:0]};
            FMT_BGR24:  word = {8'd0, data_byte, partial_reg[15:0]};
            default:    word = {data_byte, partial_reg};
        endcase
    end

    // Next state and result
    always_comb begin
        pixels_left_next   = pixels_left_reg;
        packet_left_next   = packet_left_reg;
        packet_is_run_next = packet_is_run_reg;
        byte_phase_next    = byte_phase_reg;
        partial_next       = partial_reg;
        res_valid          = 1'b0;
        repeat_raw         = 8'd1;
        repeat_sat         = 8'd1;
        res.pixel_value    = widen(cfg.pixel_format, word);
        res.repeat_count   = 8'd1;
        res.image_end      = 1'b0;

        if (restart) begin
            pixels_left_next   = restart_pixels;
            packet_left_next   = 8'd0;
            packet_is_run_next = 1'b0;
            byte_phase_next    = 2'd0;
            partial_next       = 24'd0;
        end else if (fire && pixels_left_reg != 32'd0
                     && !(cfg.run_length_coded && cfg.pixel_format == FMT_GRAY8)) begin
            if (cfg.run_length_coded && packet_left_reg == 8'd0) begin
                // Packet header: load count and run flag
                packet_left_next   = {1'b0, data_byte[6:0] & COUNT_MASK} + 8'd1;
                packet_is_run_next = (data_byte & RUN_FLAG) != 8'd0;
                byte_phase_next    = 2'd0;
                partial_next       = 24'd0;
            end else if (byte_phase_reg < cfg.pixel_format) begin
                // Gather a leading byte of the pixel
                case (byte_phase_reg)
                    2'd0:    partial_next = {partial_reg[23:8], data_byte};
                    2'd1:    partial_next = {partial_reg[23:16], data_byte, partial_reg[7:0]};
                    default: partial_next = {data_byte, partial_reg[15:0]};
                endcase
                byte_phase_next = byte_phase_reg + 2'd1;
            end else begin
                // Pixel complete: work out its repeat and retire it
                byte_phase_next = 2'd0;
                partial_next    = 24'd0;
                if (cfg.run_length_coded) begin
                    if (packet_is_run_reg) begin
                        repeat_raw       = packet_left_reg;
                        packet_left_next = 8'd0;
                    end else begin
                        packet_left_next = packet_left_reg - 8'd1;
                    end
                end
                if ({24'd0, repeat_raw} > pixels_left_reg) begin
                    repeat_sat = pixels_left_reg[7:0];
                end else begin
                    repeat_sat = repeat_raw;
                end
                pixels_left_next = pixels_left_reg - {24'd0, repeat_sat};
                res_valid        = 1'b1;
                res.repeat_count = repeat_sat;
                res.image_end    = pixels_left_next == 32'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixels_left_reg   <= 32'd1;
            packet_left_reg   <= 8'd0;
            packet_is_run_reg <= 1'b0;
            byte_phase_reg    <= 2'd0;
            partial_reg       <= 24'd0;
        end else begin
            pixels_left_reg   <= pixels_left_next;
            packet_left_reg   <= packet_left_next;
            packet_is_run_reg <= packet_is_run_next;
            byte_phase_reg    <= byte_phase_next;
            partial_reg       <= partial_next;
        end
    end

    assign status.image_done = pixels_left_reg == 32'd0;

endmodule

FILE: src/tpsd_out_buf.sv
// ----------------------------------------------------------------------------
// tpsd_out_buf
// Result register with a skid stage, so that a new result is taken while the
// held one still waits on the downstream side.
// ----------------------------------------------------------------------------
module tpsd_out_buf (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tpsd_pkg::res_t push_data,
    output logic           push_ready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output tpsd_pkg::res_t m_data
);
    import tpsd_pkg::*;

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_reg, out_next;
    res_t skid_reg, skid_next;
    logic pop;

    assign pop        = out_valid_reg && m_tready;
    assign push_ready = !skid_valid_reg;

    // Refill a free output from skid, else from push; else push into skid
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (pop || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = push_data;
                out_valid_next = push;
            end
        end else if (push) begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_data   = out_reg;

endmodule

FILE: src/tga_pixel_stream_decoder_core.sv
// An accepted input beat is held in the input register, decoded when it
// fires, and its result is registered in the output buffer that drives m_.
// Throughput: one input beat per cycle while the skid stage is free; the
// packet state update is a registered loop in the decoder, and the skid stage
// keeps input flowing while a result waits. Configuration writes are taken
// once the input register has emptied. Reset (aresetn low, synchronous):
// 32-bit BGRA, plain mode, a 1x1 image, no beats held.
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder_core
// TGA image-data decoder: bytes in, BGRA pixels with repeat counts out.
// ----------------------------------------------------------------------------
module tga_pixel_stream_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    // Decoded pixel stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [31:0] pixel_value, [39:32] repeat_count
    output logic        m_tlast,    // image_end
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import tpsd_pkg::*;

    logic        rle_reg, rle_next;
    pixel_fmt_t  fmt_reg, fmt_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic        restart;
    logic [31:0] restart_pixels;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        fire;
    logic        buf_ready;

    cfg_t        cfg;
    res_t        res;
    res_t        m_res;
    logic        res_valid;
    dec_status_t status;

    // Configuration registers; any valid write to a known register restarts the image.
    // Take a write only once the held input beat has been decoded.
    assign cfg_ready = !in_valid_reg;

    always_comb begin
        rle_next    = rle_reg;
        fmt_next    = fmt_reg;
        width_next  = width_reg;
        height_next = height_reg;
        restart     = 1'b0;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_RUN_LENGTH: begin
                    rle_next = cfg_data[0];
                    restart  = 1'b1;
                end
                REG_PIXEL_FORMAT: begin
                    fmt_next = pixel_fmt_t'(cfg_data[1:0]);
                    restart  = 1'b1;
                end
                REG_IMAGE_WIDTH: begin
                    width_next = cfg_data;
                    restart    = 1'b1;
                end
                REG_IMAGE_HEIGHT: begin
                    height_next = cfg_data;
                    restart     = 1'b1;
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    assign restart_pixels = {16'd0, width_next} * {16'd0, height_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rle_reg    <= 1'b0;
            fmt_reg    <= FMT_BGRA32;
            width_reg  <= 16'd1;
            height_reg <= 16'd1;
        end else begin
            rle_reg    <= rle_next;
            fmt_reg    <= fmt_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign cfg = '{run_length_coded: rle_reg, pixel_format: fmt_reg};

    // Input register: hold a beat until the decoder can retire it
    assign fire     = in_valid_reg && buf_ready;
    assign s_tready = !in_valid_reg || fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    tpsd_decode u_decode (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .fire           (fire),
        .data_byte      (in_byte_reg),
        .cfg            (cfg),
        .restart        (restart),
        .restart_pixels (restart_pixels),
        .res_valid      (res_valid),
        .res            (res),
        .status         (status)
    );

    tpsd_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (fire && res_valid),
        .push_data  (res),
        .push_ready (buf_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_data     (m_res)
    );

    assign m_tdata = {m_res.repeat_count, m_res.pixel_value};
    assign m_tlast = m_res.image_end;

    // A result that closes the image leaves the pixel counter at zero
    a_end_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res_valid && res.image_end && !restart |=> status.image_done)
        else $error("image end given but pixels remain");

    // Every result carries a non-zero repeat count
    a_repeat_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res_valid |-> res.repeat_count != 8'd0)
        else $error("zero repeat count");

    // No result once the image is complete
    a_quiet_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        status.image_done |-> !res_valid)
        else $error("result after image end");

    // Reset leaves no beat on the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the TGA pixel stream decoder core.
// A directed table covers reset values, every pixel format, run and raw
// packets, the saturated last repeat, the ignored run-length gray mode and a
// zero-sized image. Random image set-ups follow. Each accepted byte steps a
// local decoder model, and every result beat is compared with the oldest
// expected pixel. Both stream sides idle at random; the output is held off
// once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
    import tpsd_pkg::*;

    localparam int         CLK_PERIOD   = 8;
    localparam int         RESET_CYCLES = 5;
    localparam int         RANDOM_ITEMS = 600;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         PRINT_LIMIT  = 40;
    // An index that selects no register
    localparam logic [7:0] REG_NONE     = 8'hFF;

    typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;

    // One row of the directed table: a byte or a register write
    typedef struct packed {
        row_kind_t   kind;
        logic        typed;
        logic [7:0]  addr;
        logic [15:0] data;
        res_t        want;
    } dir_row_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;

    // Decoder model: configuration and image state
    logic        cfg_rle;
    pixel_fmt_t  cfg_fmt;
    logic [15:0] cfg_w;
    logic [15:0] cfg_h;
    logic [31:0] px_left;
    logic [7:0]  pkt_left;
    logic        pkt_run;
    logic [1:0]  gather_cnt;
    logic [23:0] gathered;

    res_t        expected_pixels[$];
    dir_row_t    dir_table[$];
    res_t        beat_want;

    int          burst_left     = 0;
    int          bytes_decoded  = 0;
    int          results_checked = 0;
    int          setups_run     = 0;
    int          mismatches     = 0;
    int          cycle_count    = 0;
    bit          hold_off_req   = 1'b0;

    tga_pixel_stream_decoder_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Widen a gathered pixel word to BGRA
    function automatic logic [31:0] expand_pixel(pixel_fmt_t fmt, logic [31:0] word);
        case (fmt)
            FMT_GRAY8:  return {24'h0, word[7:0]};
            FMT_ARGB16: return {word[15], 7'h0, word[14:10], 3'h0,
                                word[9:5], 3'h0, word[4:0], 3'h0};
            FMT_BGR24:  return {OPAQUE_ALPHA, word[23:0]};
            default:    return word;
        endcase
    endfunction

    // Restart the image from the current size
    task automatic reload_image();
        px_left    = {16'h0, cfg_w} * {16'h0, cfg_h};
        pkt_left   = 8'h0;
        pkt_run    = 1'b0;
        gather_cnt = 2'd0;
        gathered   = 24'h0;
    endtask

    task automatic apply_reg(input logic [7:0] idx, input logic [15:0] val);
        case (idx)
            REG_RUN_LENGTH:   cfg_rle = val[0];
            REG_PIXEL_FORMAT: cfg_fmt = pixel_fmt_t'(val[1:0]);
            REG_IMAGE_WIDTH:  cfg_w   = val;
            REG_IMAGE_HEIGHT: cfg_h   = val;
            default:          return;
        endcase
        reload_image();
    endtask

    // Step the model by one byte
    task automatic decode_byte(input logic [7:0] b, output bit has_res, output bit used,
                               output res_t r);
        logic [31:0] word;
        logic [31:0] rep;
        has_res = 1'b0;
        used    = 1'b0;
        r       = '0;
        if (px_left == 32'h0 || (cfg_rle && cfg_fmt == FMT_GRAY8))
            return;
        used = 1'b1;
        // open a packet
        if (cfg_rle && pkt_left == 8'h0) begin
            pkt_left   = (b & {1'b0, COUNT_MASK}) + 8'd1;
            pkt_run    = (b & RUN_FLAG) != 8'h0;
            gather_cnt = 2'd0;
            gathered   = 24'h0;
            return;
        end
        // gather the leading bytes of a pixel
        if (gather_cnt < cfg_fmt) begin
            gathered   = gathered | ({16'h0, b} << (8 * gather_cnt));
            gather_cnt = gather_cnt + 2'd1;
            return;
        end
        word       = {8'h0, gathered} | ({24'h0, b} << (8 * cfg_fmt));
        gather_cnt = 2'd0;
        gathered   = 24'h0;
        if (cfg_rle && pkt_run) begin
            rep      = {24'h0, pkt_left};
            pkt_left = 8'h0;
        end else begin
            rep = 32'd1;
            if (cfg_rle)
                pkt_left = pkt_left - 8'd1;
        end
        // saturate the last repeat
        if (rep > px_left)
            rep = px_left;
        px_left        = px_left - rep;
        r.pixel_value  = expand_pixel(cfg_fmt, word);
        r.repeat_count = rep[7:0];
        r.image_end    = (px_left == 32'h0);
        has_res        = 1'b1;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] wanted);
        if (mismatches < PRINT_LIMIT)
            $display("MISMATCH cycle %0d: %s got 0x%0h, wanted 0x%0h",
                     cycle_count, what, got, wanted);
        mismatches++;
    endtask

    // Offer one byte, in bursts with random gaps
    task automatic send_byte(input logic [7:0] b, input bit typed, input res_t want);
        int   gap;
        bit   has_res;
        bit   used;
        res_t r;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        decode_byte(b, has_res, used, r);
        if (has_res)
            expected_pixels.push_back(typed ? want : r);
        if (used)
            bytes_decoded++;
    endtask

    // Hold the sender until every expected pixel is out, then let the pipe settle
    task automatic wait_drained();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        apply_reg(idx, val);
    endtask

    task automatic configure(input logic rle, input pixel_fmt_t fmt,
                             input logic [15:0] w, input logic [15:0] h);
        write_reg(REG_RUN_LENGTH, {15'h0, rle});
        write_reg(REG_PIXEL_FORMAT, {14'h0, fmt});
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        setups_run++;
    endtask

    function automatic dir_row_t row_byte(input logic [7:0] b);
        return '{kind: ROW_BYTE, typed: 1'b0, addr: 8'h0, data: {8'h0, b}, want: '0};
    endfunction

    function automatic dir_row_t row_pix(input logic [7:0] b, input logic [31:0] pix,
                                         input logic [7:0] rep, input logic last);
        return '{kind: ROW_BYTE, typed: 1'b1, addr: 8'h0, data: {8'h0, b},
                 want: '{image_end: last, repeat_count: rep, pixel_value: pix}};
    endfunction

    function automatic dir_row_t row_reg(input logic [7:0] idx, input logic [15:0] val);
        return '{kind: ROW_REG, typed: 1'b0, addr: idx, data: val, want: '0};
    endfunction

    task automatic fill_directed_table();
        // reset set-up: 1x1 BGRA32, then a byte past the image end
        dir_table.push_back(row_byte(8'h00));
        dir_table.push_back(row_byte(8'hFF));
        dir_table.push_back(row_byte(8'h00));
        dir_table.push_back(row_pix(8'hFF, 32'hFF00FF00, 8'd1, 1'b1));
        dir_table.push_back(row_byte(8'h5A));
        // gray, two pixels at the byte extremes
        dir_table.push_back(row_reg(REG_PIXEL_FORMAT, {14'h0, FMT_GRAY8}));
        dir_table.push_back(row_reg(REG_IMAGE_WIDTH, 16'd2));
        dir_table.push_back(row_pix(8'h00, 32'h00000000, 8'd1, 1'b0));
        dir_table.push_back(row_pix(8'hFF, 32'h000000FF, 8'd1, 1'b1));
        // A1R5G5B5 with alpha clear and set
        dir_table.push_back(row_reg(REG_PIXEL_FORMAT, {14'h0, FMT_ARGB16}));
        dir_table.push_back(row_byte(8'hFF));
        dir_table.push_back(row_pix(8'h7F, 32'h00F8F8F8, 8'd1, 1'b0));
        dir_table.push_back(row_byte(8'h00));
        dir_table.push_back(row_pix(8'h80, 32'h80000000, 8'd1, 1'b1));
        // BGR24 gets opaque alpha
        dir_table.push_back(row_reg(REG_PIXEL_FORMAT, {14'h0, FMT_BGR24}));
        dir_table.push_back(row_reg(REG_IMAGE_WIDTH, 16'd1));
        dir_table.push_back(row_byte(8'h01));
        dir_table.push_back(row_byte(8'h02));
        dir_table.push_back(row_pix(8'h03, 32'hFF030201, 8'd1, 1'b1));
        // run of 128 saturated to the five pixels of the image
        dir_table.push_back(row_reg(REG_RUN_LENGTH, 16'd1));
        dir_table.push_back(row_reg(REG_IMAGE_HEIGHT, 16'd5));
        dir_table.push_back(row_byte(8'hFF));
        dir_table.push_back(row_byte(8'h10));
        dir_table.push_back(row_byte(8'h20));
        dir_table.push_back(row_pix(8'h30, 32'hFF302010, 8'd5, 1'b1));
        // run-length gray is not supported: byte dropped
        dir_table.push_back(row_reg(REG_PIXEL_FORMAT, {14'h0, FMT_GRAY8}));
        dir_table.push_back(row_byte(8'h81));
        // zero-sized image drops everything; a bad index changes nothing
        dir_table.push_back(row_reg(REG_RUN_LENGTH, 16'd0));
        dir_table.push_back(row_reg(REG_PIXEL_FORMAT, {14'h0, FMT_BGRA32}));
        dir_table.push_back(row_reg(REG_IMAGE_WIDTH, 16'd0));
        dir_table.push_back(row_byte(8'h55));
        dir_table.push_back(row_reg(REG_NONE, 16'hFFFF));
        // largest image, raw packet then a run of one
        dir_table.push_back(row_reg(REG_IMAGE_WIDTH, 16'hFFFF));
        dir_table.push_back(row_reg(REG_IMAGE_HEIGHT, 16'hFFFF));
        dir_table.push_back(row_reg(REG_PIXEL_FORMAT, {14'h0, FMT_ARGB16}));
        dir_table.push_back(row_reg(REG_RUN_LENGTH, 16'd1));
        dir_table.push_back(row_byte(8'h00));
        dir_table.push_back(row_byte(8'h34));
        dir_table.push_back(row_byte(8'h12));
        dir_table.push_back(row_byte(8'h80));
        dir_table.push_back(row_byte(8'hFF));
        dir_table.push_back(row_byte(8'hFF));
    endtask

    // One random image set-up followed by a mostly well-formed byte stream
    task automatic random_image();
        logic       rle;
        pixel_fmt_t fmt;
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0] hdr;
        longint     remaining;
        int         budget;
        int         sent;
        int         bpp;
        int         cnt;
        int         npix;
        rle = 1'($urandom_range(0, 1));
        fmt = pixel_fmt_t'($urandom_range(0, 3));
        case ($urandom_range(0, 15))
            0:       begin w = 16'd0; h = 16'($urandom_range(0, 65535)); end
            1:       begin w = 16'($urandom_range(1, 65535)); h = 16'd0; end
            2:       begin w = 16'hFFFF; h = 16'($urandom_range(1, 3)); end
            3:       begin w = 16'($urandom_range(1, 3)); h = 16'hFFFF; end
            4:       begin w = 16'd1; h = 16'd1; end
            default: begin w = 16'($urandom_range(1, 8)); h = 16'($urandom_range(1, 6)); end
        endcase
        configure(rle, fmt, w, h);
        bpp       = int'(fmt) + 1;
        remaining = longint'(w) * longint'(h);
        budget    = (remaining > 64) ? $urandom_range(8, 48) : 320;
        if (rle && fmt == FMT_GRAY8)
            budget = $urandom_range(2, 8);
        sent = 0;
        while (remaining > 0 && sent < budget) begin
            if (rle) begin
                // packet header, mostly short counts
                cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 128)
                                                  : $urandom_range(1, 8);
                hdr    = 8'(cnt - 1);
                hdr[7] = 1'($urandom_range(0, 1));
                send_byte(hdr, 1'b0, '0);
                npix = hdr[7] ? 1 : cnt;
                repeat (npix * bpp) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
                sent      += 1 + npix * bpp;
                remaining -= cnt;
            end else begin
                repeat (bpp) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
                sent      += bpp;
                remaining -= 1;
            end
        end
        // trailing noise, possibly a broken pixel or header
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    // Output side: random stall patterns, and a long hold-off on request
    initial begin
        int       hold_left;
        int       stretch_left;
        rx_mode_t mode;
        hold_left    = 0;
        stretch_left = 0;
        mode         = RX_ALWAYS;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                if (stretch_left == 0) begin
                    mode         = rx_mode_t'($urandom_range(0, 3));
                    stretch_left = $urandom_range(16, 64);
                end
                stretch_left--;
                case (mode)
                    RX_ALWAYS: m_tready <= 1'b1;
                    RX_HALF:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= stretch_left[0];
                endcase
            end
        end
    end

    // Compare each result beat with the oldest expected pixel
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("result beat with nothing pending", m_tdata[31:0], 32'h0);
            end else begin
                beat_want = expected_pixels.pop_front();
                if (m_tdata[31:0] != beat_want.pixel_value)
                    report_mismatch("pixel_value", m_tdata[31:0], beat_want.pixel_value);
                if (m_tdata[39:32] != beat_want.repeat_count)
                    report_mismatch("repeat_count", {24'h0, m_tdata[39:32]},
                                    {24'h0, beat_want.repeat_count});
                if (m_tlast != beat_want.image_end)
                    report_mismatch("image_end", {31'h0, m_tlast},
                                    {31'h0, beat_want.image_end});
                results_checked++;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d pixels pending",
                     cycle_count, expected_pixels.size());
            $display("** tga_pixel_stream_decoder_core: FAILED **");
            $finish;
        end
    end

    // Stimulus
    initial begin
        dir_row_t row;
        int       start_cnt;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h0;
        cfg_valid <= 1'b0;
        cfg_index <= 8'h0;
        cfg_data  <= 16'h0;
        aresetn   <= 1'b0;
        cfg_rle = 1'b0;
        cfg_fmt = FMT_BGRA32;
        cfg_w   = 16'd1;
        cfg_h   = 16'd1;
        reload_image();
        fill_directed_table();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // walk the directed table
        foreach (dir_table[i]) begin
            row = dir_table[i];
            if (row.kind == ROW_REG)
                write_reg(row.addr, row.data);
            else
                send_byte(row.data[7:0], row.typed, row.want);
        end

        // hold the output off while a gray stream fills the block
        configure(1'b0, FMT_GRAY8, 16'd64, 16'd1);
        hold_off_req = 1'b1;
        repeat (64) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        wait_drained();

        // random image set-ups
        start_cnt = bytes_decoded;
        while (bytes_decoded - start_cnt < RANDOM_ITEMS)
            random_image();
        wait_drained();

        $display("Run covered %0d decoded bytes, %0d pixel beats, %0d image set-ups,",
                 bytes_decoded, results_checked, setups_run);
        $display("all four formats, plain and run-length packets, one long output hold-off.");
        if (mismatches == 0)
            $display("** tga_pixel_stream_decoder_core: PASSED **");
        else
            $display("** tga_pixel_stream_decoder_core: FAILED **");
        $finish;
    end

endmodule
